// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tone generator blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked assertion with explicit clock and reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in tone generator");

// assertion on the standard clock and reset of this project
`define ASSERT_STD(label, prop) \
   `ASSERT_CLK(label, clock, reset, prop)

`endif

// ----- sv/estg_pkg.sv -----
// ----------------------------------------------------------------------------
// estg_pkg
// Types, constants and the sine table function of the tone generator.
// ----------------------------------------------------------------------------
package estg_pkg;

   localparam int DEF_SAMPLE_RATE_HZ  = 16000;
   localparam int DEF_PHASE_BITS      = 32;
   localparam int DEF_SINE_TABLE_BITS = 8;

   localparam int FIELD_W   = 16;
   localparam int COUNT_W   = 21;
   localparam int MAG_W     = 15;
   localparam int ENV_W     = 17;
   localparam int ENV_SHIFT = 16;
   localparam int ENV_CMP_W = 26;
   localparam int VOL_W     = 7;
   localparam int VOLAMP_W  = 21;
   localparam int PROD1_W   = MAG_W + ENV_W;
   localparam int PROD2_W   = PROD1_W + VOLAMP_W;
   localparam int PROD_SHIFT = 31;
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 21;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam int AMPLITUDE   = 16000;
   localparam int MS_PER_S    = 1000;
   localparam int VOL_MAX     = 100;
   localparam int VOL_RESET   = 80;
   localparam int ENV_ONE     = 65536;
   localparam int ENV_UP_DIV  = 20;
   localparam int ENV_DN_DIV  = 10;
   localparam int ENV_DN_KEEP = 9;

   localparam longint unsigned SC1 = 64'd1686629713;
   localparam longint unsigned SC3 = 64'd693598668;
   localparam longint unsigned SC5 = 64'd85569306;
   localparam longint unsigned SC7 = 64'd5026995;
   localparam longint unsigned SC9 = 64'd172272;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic take;
      logic div_total;
      logic div_inc;
      logic commit_start;
      logic lookup;
      logic mul1;
      logic mul2;
      logic div_vol;
      logic emit_tone;
      logic emit_idle;
   } ctl_cmd_type;

   typedef struct packed {
      logic tick;
      logic tone_busy;
      logic env_ramp;
      logic div_done;
      logic rsp_free;
   } ctl_status_type;

   // Q15 quarter-wave sine of (x / 2^30) * pi/2, odd polynomial in Q30
   function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x2 = (x * x) >> 30;
      t  = SC9;
      t  = SC7 - ((x2 * t) >> 30);
      t  = SC5 - ((x2 * t) >> 30);
      t  = SC3 - ((x2 * t) >> 30);
      t  = SC1 - ((x2 * t) >> 30);
      s  = (x * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         return {MAG_W{1'b1}};
      end
      return s[MAG_W-1:0];
   endfunction

endpackage

// ----- sv/estg_divider.sv -----
// ----------------------------------------------------------------------------
// estg_divider
// Shared restoring divider, two quotient bits per clock.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module estg_divider #(
   parameter int NUM_W = estg_pkg::DIV_NUM_W,   // must be even
   parameter int DEN_W = estg_pkg::DIV_DEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int STEPS = NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int j = 0; j < 2; j++) begin
         trial  = {rem_in, quo_in[NUM_W-1]};
         quo_in = {quo_in[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial     = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numer;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(STEPS);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNT_W'(1));
         done_ff <= (cnt_ff == CNT_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

   `ASSERT_STD(a_start_when_free, start |-> !busy_ff)
   `ASSERT_STD(a_done_pulse, done_ff |=> !done_ff)

endmodule

// ----- sv/estg_ctrl.sv -----
// ----------------------------------------------------------------------------
// estg_ctrl
// Sequencer for start and tick items of the tone generator.
// ----------------------------------------------------------------------------
module estg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  estg_pkg::ctl_status_type status,
   output estg_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TOT_GO,
      ST_TOT_WAIT,
      ST_INC_GO,
      ST_INC_WAIT,
      ST_IDLE_OUT,
      ST_LOOKUP,
      ST_ENV_WAIT,
      ST_MUL1,
      ST_MUL2,
      ST_VOL_GO,
      ST_VOL_WAIT,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!status.tick) state_in = ST_TOT_GO;
            else if (!status.tone_busy) state_in = ST_IDLE_OUT;
            else state_in = ST_LOOKUP;
         end
         ST_TOT_GO:   state_in = ST_TOT_WAIT;
         ST_TOT_WAIT: begin
            if (status.div_done) state_in = ST_INC_GO;
         end
         ST_INC_GO:   state_in = ST_INC_WAIT;
         ST_INC_WAIT: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         ST_IDLE_OUT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = status.env_ramp ? ST_ENV_WAIT : ST_MUL1;
         end
         ST_ENV_WAIT: begin
            if (status.div_done) state_in = ST_MUL1;
         end
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_VOL_GO;
         ST_VOL_GO:   state_in = ST_VOL_WAIT;
         ST_VOL_WAIT: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready       = (state_ff == ST_IDLE);
   assign cmd.take         = (state_ff == ST_IDLE);
   assign cmd.div_total    = (state_ff == ST_TOT_GO);
   assign cmd.div_inc      = (state_ff == ST_INC_GO);
   assign cmd.commit_start = (state_ff == ST_INC_WAIT) && status.div_done;
   assign cmd.lookup       = (state_ff == ST_LOOKUP);
   assign cmd.mul1         = (state_ff == ST_MUL1);
   assign cmd.mul2         = (state_ff == ST_MUL2);
   assign cmd.div_vol      = (state_ff == ST_VOL_GO);
   assign cmd.emit_tone    = (state_ff == ST_EMIT) && status.rsp_free;
   assign cmd.emit_idle    = (state_ff == ST_IDLE_OUT) && status.rsp_free;

endmodule

// ----- sv/estg_datapath.sv -----
// ----------------------------------------------------------------------------
// estg_datapath
// Tone state, sine lookup, envelope, scaling and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module estg_datapath #(
   parameter int SAMPLE_RATE_HZ  = estg_pkg::DEF_SAMPLE_RATE_HZ,
   parameter int PHASE_BITS      = estg_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = estg_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic [2*estg_pkg::FIELD_W-1:0]        req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [estg_pkg::FIELD_W-1:0]          rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [estg_pkg::VOL_W-1:0]            csr_wdata,
   input  estg_pkg::ctl_cmd_type                 cmd,
   output estg_pkg::ctl_status_type              status
);

   localparam int FW    = estg_pkg::FIELD_W;
   localparam int CW    = estg_pkg::COUNT_W;
   localparam int MW    = estg_pkg::MAG_W;
   localparam int EW    = estg_pkg::ENV_W;
   localparam int ECW   = estg_pkg::ENV_CMP_W;
   localparam int NW    = estg_pkg::DIV_NUM_W;
   localparam int DW    = estg_pkg::DIV_DEN_W;
   localparam int QB    = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QB;
   localparam int POS_W = QB + 1;

   typedef logic [MW-1:0] rom_type [QSIZE+1];

   function automatic rom_type build_rom();
      rom_type t;
      for (int p = 0; p <= QSIZE; p++) begin
         t[p] = estg_pkg::quarter_sine(64'(p) << (30 - QB));
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // input item
   logic          tick_ff;
   logic [FW-1:0] freq_ff;
   logic [FW-1:0] dur_ff;

   // tone state
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] inc_ff;
   logic [CW-1:0]         idx_ff;
   logic [CW-1:0]         total_ff;
   logic [CW-1:0]         total_tmp_ff;
   logic                  busy_ff;
   logic [estg_pkg::VOLAMP_W-1:0] volamp_ff;

   // sample pipeline
   logic [MW-1:0]                  mag_ff;
   logic                           neg_ff;
   logic                           ramp_ff;
   logic [estg_pkg::PROD1_W-1:0]   prod1_ff;
   logic [estg_pkg::PROD2_W-1:0]   prod2_ff;

   // output register
   logic          rsp_valid_ff;
   logic [MW-1:0] rsp_sample_ff;
   logic          rsp_active_ff;
   logic          rsp_last_ff;

   // divider
   logic          div_start;
   logic [NW-1:0] div_numer;
   logic [DW-1:0] div_denom;
   logic          div_busy;
   logic          div_done;
   logic [NW-1:0] div_quot;

   logic [SINE_TABLE_BITS-1:0] tbl_k;
   logic [POS_W-1:0]           tbl_pos;
   logic [ECW-1:0]             i20;
   logic [ECW-1:0]             i10;
   logic [ECW-1:0]             n1;
   logic [ECW-1:0]             n9;
   logic [ECW-1:0]             down_num;
   logic                       ramp_up;
   logic                       ramp_dn;
   logic [NW-1:0]              env_numer;
   logic [CW:0]                idx_next;
   logic                       last_flag;
   logic [EW-1:0]              env_val;
   logic [MW-1:0]              vol_mag;
   logic [CW-1:0]              total_sat;
   logic [estg_pkg::VOL_W-1:0] vol_sat;
   logic                       rsp_free;

   // sine table addressing with quadrant symmetry
   assign tbl_k   = acc_ff[PHASE_BITS-1 -: SINE_TABLE_BITS];
   assign tbl_pos = tbl_k[QB] ? (POS_W'(QSIZE) - {1'b0, tbl_k[QB-1:0]})
                              : {1'b0, tbl_k[QB-1:0]};

   // envelope region
   assign i20      = ECW'(idx_ff) * ECW'(estg_pkg::ENV_UP_DIV);
   assign i10      = ECW'(idx_ff) * ECW'(estg_pkg::ENV_DN_DIV);
   assign n1       = ECW'(total_ff);
   assign n9       = ECW'(total_ff) * ECW'(estg_pkg::ENV_DN_KEEP);
   assign down_num = ECW'(total_ff - idx_ff) * ECW'(estg_pkg::ENV_DN_DIV);
   assign ramp_up  = (i20 < n1);
   assign ramp_dn  = (i10 > n9);
   assign env_numer = ramp_up ? (NW'(i20) << estg_pkg::ENV_SHIFT)
                              : (NW'(down_num) << estg_pkg::ENV_SHIFT);

   assign idx_next  = {1'b0, idx_ff} + 1'b1;
   assign last_flag = (idx_next >= {1'b0, total_ff});
   assign env_val   = ramp_ff ? div_quot[EW-1:0] : EW'(estg_pkg::ENV_ONE);
   assign vol_mag   = div_quot[MW-1:0];
   assign total_sat = (div_quot > NW'(estg_pkg::COUNT_MAX)) ? estg_pkg::COUNT_MAX
                                                              : div_quot[CW-1:0];
   assign vol_sat   = (csr_wdata > estg_pkg::VOL_W'(estg_pkg::VOL_MAX))
                      ? estg_pkg::VOL_W'(estg_pkg::VOL_MAX) : csr_wdata;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // shared divider operand selection
   assign div_start = cmd.div_total || cmd.div_inc || cmd.div_vol ||
                      (cmd.lookup && ramp_up) || (cmd.lookup && ramp_dn);

   always_comb begin
      div_numer = env_numer;
      div_denom = total_ff;
      if (cmd.div_total) begin
         div_numer = NW'(SAMPLE_RATE_HZ) * NW'(dur_ff);
         div_denom = DW'(estg_pkg::MS_PER_S);
      end else if (cmd.div_inc) begin
         div_numer = NW'(freq_ff) << PHASE_BITS;
         div_denom = DW'(SAMPLE_RATE_HZ);
      end else if (cmd.div_vol) begin
         div_numer = NW'(prod2_ff >> estg_pkg::PROD_SHIFT);
         div_denom = DW'(estg_pkg::VOL_MAX);
      end
   end

   estg_divider #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take && req_tvalid) begin
         tick_ff <= (req_tuser == estg_pkg::REQ_TICK);
         freq_ff <= req_tdata[FW-1:0];
         dur_ff  <= req_tdata[2*FW-1:FW];
      end
      if (cmd.div_inc) begin
         total_tmp_ff <= total_sat;
      end
      if (cmd.lookup) begin
         mag_ff  <= SINE_ROM[tbl_pos];
         neg_ff  <= tbl_k[SINE_TABLE_BITS-1];
         ramp_ff <= ramp_up || ramp_dn;
      end
      if (cmd.mul1) begin
         prod1_ff <= mag_ff * env_val;
      end
      if (cmd.mul2) begin
         prod2_ff <= estg_pkg::PROD2_W'(prod1_ff) * estg_pkg::PROD2_W'(volamp_ff);
      end
      if (cmd.emit_tone) begin
         rsp_sample_ff <= neg_ff ? (MW'(0) - vol_mag) : vol_mag;
         rsp_active_ff <= 1'b1;
         rsp_last_ff   <= last_flag;
      end else if (cmd.emit_idle) begin
         rsp_sample_ff <= '0;
         rsp_active_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end
   end

   // tone state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         inc_ff       <= '0;
         idx_ff       <= '0;
         total_ff     <= '0;
         busy_ff      <= 1'b0;
         volamp_ff    <= estg_pkg::VOLAMP_W'(estg_pkg::VOL_RESET * estg_pkg::AMPLITUDE);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            volamp_ff <= estg_pkg::VOLAMP_W'(vol_sat) *
                         estg_pkg::VOLAMP_W'(estg_pkg::AMPLITUDE);
         end
         if (cmd.commit_start) begin
            acc_ff   <= '0;
            idx_ff   <= '0;
            inc_ff   <= div_quot[PHASE_BITS-1:0];
            total_ff <= total_tmp_ff;
            busy_ff  <= (total_tmp_ff != '0);
         end else if (cmd.emit_tone) begin
            acc_ff  <= acc_ff + inc_ff;
            idx_ff  <= idx_next[CW-1:0];
            busy_ff <= !last_flag;
         end
         if (cmd.emit_tone || cmd.emit_idle) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.tick      = tick_ff;
   assign status.tone_busy = busy_ff;
   assign status.env_ramp  = ramp_up || ramp_dn;
   assign status.div_done  = div_done;
   assign status.rsp_free  = rsp_free && !div_busy;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_sample_ff};
   assign rsp_tuser  = rsp_active_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_STD(a_index_below_total, busy_ff |-> (idx_ff < total_ff))
   `ASSERT_STD(a_load_only_when_free, (cmd.emit_tone || cmd.emit_idle) |-> rsp_free)
   `ASSERT_STD(a_sample_in_range, rsp_valid_ff |-> (($signed(rsp_sample_ff) <= $signed(MW'(estg_pkg::AMPLITUDE))) && ($signed(rsp_sample_ff) >= -$signed(MW'(estg_pkg::AMPLITUDE)))))

endmodule

// ----- sv/enveloped_sine_tone_generator.sv -----
// ----------------------------------------------------------------------------
// enveloped_sine_tone_generator
// Sine tone generator with phase accumulator, linear envelope and volume.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = 0 starts a tone (tdata = frequency in Hz, duration
//   in ms), tuser = 1 is a sample tick. A start gives no item on rsp; each
//   tick gives exactly one rsp item, in order.
//   rsp channel: tdata holds the signed sample, tuser is high for a tone
//   sample, tlast marks the final sample of the tone. Idle ticks give zero.
//   csr_we/csr_wdata write the volume in percent (above 100 stored as 100);
//   write only while no item is in flight.
// Timing: one item at a time, all divisions through one shared divider that
//   retires 2 quotient bits a cycle. A start takes two divisions, a tick on
//   the envelope plateau one (volume) and a tick on the ramps two (envelope
//   and volume); an idle tick takes none.
// Reset clears the tone (idle), volume returns to 80 percent. A stalled rsp
//   holds its item in the output register; the next req item is still taken,
//   and its result waits until that register is free.
// ----------------------------------------------------------------------------
module enveloped_sine_tone_generator #(
   parameter int SAMPLE_RATE_HZ  = estg_pkg::DEF_SAMPLE_RATE_HZ,
   parameter int PHASE_BITS      = estg_pkg::DEF_PHASE_BITS,
   parameter int SINE_TABLE_BITS = estg_pkg::DEF_SINE_TABLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2*estg_pkg::FIELD_W-1:0] req_tdata,   // tone_freq_hz, tone_duration_ms
   input  logic                           req_tuser,   // cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [estg_pkg::FIELD_W-1:0]   rsp_tdata,   // sample_value, zero pad
   output logic                           rsp_tuser,   // tone_active
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [estg_pkg::VOL_W-1:0]     csr_wdata
);

   estg_pkg::ctl_cmd_type    cmd;
   estg_pkg::ctl_status_type status;

   estg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   estg_datapath #(
      .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- tb/tb_enveloped_sine_tone_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_enveloped_sine_tone_generator
// Self-checking bench: drives start and tick items with bursty timing,
// stalls the sample stream, and checks every sample against a local DDS,
// envelope and volume model run at item acceptance.
// ----------------------------------------------------------------------------
module tb_enveloped_sine_tone_generator;

   localparam int RATE_HZ        = estg_pkg::DEF_SAMPLE_RATE_HZ;
   localparam int PHASE_W        = estg_pkg::DEF_PHASE_BITS;
   localparam int TABLE_BITS     = estg_pkg::DEF_SINE_TABLE_BITS;
   localparam int QUARTER        = TABLE_BITS - 2;
   localparam int SAMPLES_PER_MS = RATE_HZ / 1000;
   localparam longint unsigned COUNT_LIMIT = 64'd2097151;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 170;

   typedef struct packed {
      estg_pkg::req_kind_type kind;
      logic [15:0]            freq_hz;
      logic [15:0]            dur_ms;
   } tone_req_t;

   typedef struct packed {
      logic [14:0] sample;
      logic        active;
      logic        last;
   } tone_sample_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // tone_freq_hz, tone_duration_ms
   logic        req_tuser = 1'b0;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // sample_value, zero pad
   logic        rsp_tuser;         // tone_active
   logic        rsp_tlast;         // last_sample
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   enveloped_sine_tone_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // tone model state
   logic [PHASE_W-1:0] phase_acc = '0;
   logic [PHASE_W-1:0] phase_step = '0;
   logic [20:0]        sample_idx = '0;
   logic [20:0]        sample_total = '0;
   logic               tone_on = 1'b0;
   int unsigned        volume_pct = 80;

   tone_req_t    queued_tone_cmds[$];
   tone_sample_t expected_samples[$];
   tone_req_t    next_req;
   tone_sample_t predicted;
   tone_sample_t want;
   int           error_count = 0;
   int           idle_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   logic [9:0]   stall_phase = '0;
   logic [15:0]  stall_mask = 16'h5A5B;

   initial begin
      forever #5 clock = ~clock;
   end

   // Q15 sine of (x / 2^30) * pi/2 from the odd degree-9 polynomial
   function automatic longint unsigned sine_q15(input longint unsigned x);
      longint unsigned coef [5];
      longint unsigned x2;
      longint unsigned acc;
      coef = '{estg_pkg::SC9, estg_pkg::SC7, estg_pkg::SC5, estg_pkg::SC3, estg_pkg::SC1};
      x2 = (x * x) >> 30;
      acc = coef[0];
      for (int j = 1; j < 5; j++) begin
         acc = coef[j] - ((x2 * acc) >> 30);
      end
      acc = (x * acc) >> 30;
      acc = (acc + 64'd16384) >> 15;
      return (acc > 64'd32767) ? 64'd32767 : acc;
   endfunction

   // linear attack over the first 5%, release over the last 10%, Q1.16
   function automatic longint unsigned envelope_gain(input longint unsigned i,
                                                     input longint unsigned n);
      if (n == 0) begin
         return 0;
      end
      if (20 * i < n) begin
         return (20 * i * 64'd65536) / n;
      end
      if (10 * i > 9 * n) begin
         return (10 * (n - i) * 64'd65536) / n;
      end
      return 64'd65536;
   endfunction

   // advances the tone model by one item; returns 1 when a sample results
   function automatic bit next_tone_sample(input tone_req_t rq, output tone_sample_t res);
      longint unsigned n64;
      longint unsigned mag;
      longint unsigned env;
      longint unsigned v;
      logic [TABLE_BITS-1:0] k;
      logic [QUARTER:0]      pos;
      logic [14:0]           mag15;
      res = '0;
      if (rq.kind == estg_pkg::REQ_START) begin
         n64 = 64'(rq.dur_ms) * RATE_HZ / 1000;
         if (n64 > COUNT_LIMIT) begin
            n64 = COUNT_LIMIT;
         end
         phase_step = PHASE_W'((64'(rq.freq_hz) << PHASE_W) / RATE_HZ);
         phase_acc = '0;
         sample_idx = '0;
         sample_total = 21'(n64);
         tone_on = (n64 != 0);
         return 1'b0;
      end
      if (!tone_on) begin
         return 1'b1;
      end
      k = phase_acc[PHASE_W-1 -: TABLE_BITS];
      pos = k[QUARTER] ? ((QUARTER+1)'(1 << QUARTER) - k[QUARTER-1:0])
                       : {1'b0, k[QUARTER-1:0]};
      mag = sine_q15(64'(pos) << (30 - QUARTER));
      env = envelope_gain(64'(sample_idx), 64'(sample_total));
      v = (mag * env * volume_pct * 64'd16000) / (64'd32768 * 64'd65536 * 64'd100);
      mag15 = v[14:0];
      res.sample = k[TABLE_BITS-1] ? -mag15 : mag15;
      res.active = 1'b1;
      res.last = (32'(sample_idx) + 1) >= 32'(sample_total);
      phase_acc = phase_acc + phase_step;
      sample_idx = sample_idx + 1'b1;
      if (res.last) begin
         tone_on = 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_freq();
      case ($urandom_range(0, 9))
         0:          return 16'd0;
         1:          return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(20, 4000));
         default:    return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic push_req(input estg_pkg::req_kind_type kind, input logic [15:0] freq,
                           input logic [15:0] dur);
      tone_req_t rq;
      rq.kind = kind;
      rq.freq_hz = freq;
      rq.dur_ms = dur;
      queued_tone_cmds.push_back(rq);
   endtask

   task automatic push_tick();
      push_req(estg_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
   endtask

   task automatic write_volume(input logic [6:0] pct);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= pct;
      volume_pct = (pct > 100) ? 100 : pct;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (queued_tone_cmds.size() != 0 || req_tvalid || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_tones(input int target);
      int          queued_n;
      int          n;
      int          ticks;
      logic [15:0] dur;
      queued_n = 0;
      while (queued_n < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: begin
               // whole tone, sometimes cut short by the next start
               dur = 16'($urandom_range(1, 6));
               n = SAMPLES_PER_MS * dur;
               ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1)
                                                  : n + $urandom_range(0, 2);
               push_req(estg_pkg::REQ_START, pick_freq(), dur);
               repeat (ticks) push_tick();
               queued_n += ticks + 1;
            end
            7: begin
               ticks = $urandom_range(0, 12);
               push_req(estg_pkg::REQ_START, pick_freq(), 16'($urandom));
               repeat (ticks) push_tick();
               queued_n += ticks + 1;
            end
            8: begin
               push_req(estg_pkg::REQ_START, pick_freq(), 16'd0);
               push_tick();
               queued_n += 2;
            end
            default: begin
               push_req(estg_pkg::req_kind_type'($urandom_range(0, 1)), 16'($urandom),
                        16'($urandom));
               queued_n += 1;
            end
         endcase
      end
   endtask

   // stimulus and phase sequencing
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_volume(7'd100);
      push_tick();
      push_req(estg_pkg::REQ_START, 16'd440, 16'd0);
      push_tick();
      push_req(estg_pkg::REQ_START, 16'hFFFF, 16'hFFFF);
      push_tick();
      push_tick();
      push_req(estg_pkg::REQ_START, 16'd3000, 16'd1);
      repeat (SAMPLES_PER_MS + 1) push_tick();
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       write_volume(7'd0);
            1:       write_volume(7'd127);
            2:       write_volume(7'd1);
            3:       write_volume(7'($urandom_range(2, 126)));
            4:       write_volume(7'd80);
            default: write_volume(7'($urandom_range(101, 127)));
         endcase
         queue_random_tones(ITEMS_PER_PHASE);
         wait_drained();
      end

      if (expected_samples.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // request driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            req_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (queued_tone_cmds.size() != 0) begin
            next_req = queued_tone_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_req.kind;
            req_tdata <= {next_req.dur_ms, next_req.freq_hz};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // sample sink: always ready for a stretch, then a rotating stall mask
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_phase <= '0;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         if (stall_phase[9:8] == 2'd0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= stall_mask[stall_phase[3:0]];
         end
         if (stall_phase == '0) begin
            stall_mask <= 16'($urandom) | 16'h0001;
         end
      end
   end

   // monitor: check samples, predict accepted items, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample: expected none, got tdata=%h tuser=%b tlast=%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata !== {1'b0, want.sample}) begin
                  $display("%0t: sample_value mismatch: expected %h, got %h",
                           $time, {1'b0, want.sample}, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.active) begin
                  $display("%0t: tone_active mismatch: expected %b, got %b",
                           $time, want.active, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_sample mismatch: expected %b, got %b",
                           $time, want.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (next_tone_sample(tone_req_t'({req_tuser, req_tdata[15:0], req_tdata[31:16]}),
                                 predicted)) begin
               expected_samples.push_back(predicted);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_count = 0;
         end else if (queued_tone_cmds.size() != 0 || req_tvalid ||
                      expected_samples.size() != 0) begin
            idle_count++;
         end
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
